// File: rtl/huffman_heap_tree_decoder_top_macros.svh
// Assertion macros for the heap tree decoder.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef HUFFMAN_HEAP_TREE_DECODER_TOP_MACROS_SVH
`define HUFFMAN_HEAP_TREE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HHTD_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HHTD_ASSERT_NXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hhtd_pkg.sv
// Package for the heap tree decoder: item types, command and status structs.
// Has no dependencies; used by the controller, the datapath and the top level.
package hhtd_pkg;

  localparam int TREE_ENTRIES = 2048;
  localparam int ADDR_W       = $clog2(TREE_ENTRIES);
  localparam int IDX_W        = ADDR_W + 2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [10:0] entry_addr;
    logic [7:0]  entry_value;
    logic [7:0]  coded_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       walk_error;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic start;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_bit;
    logic step_ok;
    logic flush_ok;
  } stat_t;

endpackage

// File: rtl/hhtd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hhtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/hhtd_ctrl.sv
// Controller of the heap tree decoder: clear pass, idle, bit walk and flush.
// Depends on hhtd_pkg; drives the datapath through cmd_t and reads stat_t.
module hhtd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_stall,
  input  hhtd_pkg::stat_t stat,
  output hhtd_pkg::cmd_t  cmd
);
  import hhtd_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r, stall_nxt;

  always_comb begin
    cmd.clr   = (state_r == ST_CLEAR);
    cmd.load  = (state_r == ST_IDLE) && in_valid && (in_func == FUNC_LOAD);
    cmd.start = (state_r == ST_IDLE) && in_valid && (in_func == FUNC_DECODE);
    cmd.step  = (state_r == ST_WALK) && stat.step_ok;
    cmd.flush = (state_r == ST_FLUSH) && stat.flush_ok;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cmd.step && stat.last_bit) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (cmd.flush) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      stall_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      stall_r <= stall_nxt;
    end
  end

  assign in_stall = stall_r;

endmodule

// File: rtl/hhtd_datapath.sv
// Datapath of the heap tree decoder: tree memory, walk index, bit shifter,
// pending result and output register. Depends on hhtd_pkg and hhtd_ram.
module hhtd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  hhtd_pkg::in_item_t  in_data,
  input  hhtd_pkg::cmd_t      cmd,
  output hhtd_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_stall,
  output hhtd_pkg::out_item_t out_data
);
  import hhtd_pkg::*;

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] walk_r, walk_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              oor_r, oor_nxt;
  logic [7:0]        bits_r, bits_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [7:0]        pend_sym_r, pend_sym_nxt;
  logic              pend_err_r, pend_err_nxt;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        rdata;

  logic              load_ok;
  logic              res_now;
  logic [ADDR_W-1:0] walk_new;
  logic [ADDR_W-1:0] base;
  logic              bit_val;
  logic [IDX_W-1:0]  idx;
  logic              idx_oor;
  logic              issue;
  logic              out_free;

  assign out_free = !out_v_r || !out_stall;
  assign load_ok  = 32'(in_data.entry_addr) < 32'(TREE_ENTRIES);

  assign res_now  = oor_r || (rdata != 8'd0);
  assign walk_new = res_now ? '0 : addr_r;

  always_comb begin
    if (cmd.start) begin
      base    = walk_r;
      bit_val = in_data.coded_byte[7];
    end else begin
      base    = walk_new;
      bit_val = bits_r[7];
    end
    idx     = (IDX_W'(base) << 1) + (bit_val ? IDX_W'(2) : IDX_W'(1));
    idx_oor = (idx >= IDX_W'(TREE_ENTRIES));
  end

  assign issue  = cmd.start || (cmd.step && (cnt_r != 3'd0));
  assign ram_re = issue && !idx_oor;

  assign ram_we    = cmd.clr || (cmd.load && load_ok);
  assign ram_waddr = cmd.clr ? clr_cnt_r : ADDR_W'(in_data.entry_addr);
  assign ram_wdata = cmd.clr ? 8'd0 : in_data.entry_value;

  hhtd_ram #(
    .WIDTH (8),
    .DEPTH (TREE_ENTRIES)
  ) u_tree (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (idx[ADDR_W-1:0]),
    .rdata_r (rdata)
  );

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    walk_nxt     = walk_r;
    addr_nxt     = addr_r;
    oor_nxt      = oor_r;
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_sym_nxt = pend_sym_r;
    pend_err_nxt = pend_err_r;
    out_v_nxt    = out_v_r && out_stall;
    out_nxt      = out_r;

    if (cmd.clr) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
    end

    if (cmd.start) begin
      addr_nxt = idx[ADDR_W-1:0];
      oor_nxt  = idx_oor;
      bits_nxt = {in_data.coded_byte[6:0], 1'b0};
      cnt_nxt  = 3'd7;
    end

    if (cmd.step) begin
      walk_nxt = walk_new;
      if (res_now) begin
        if (pend_v_r) begin
          out_v_nxt = 1'b1;
          out_nxt   = '{symbol: pend_sym_r, walk_error: pend_err_r, last: 1'b0};
        end
        pend_v_nxt   = 1'b1;
        pend_sym_nxt = oor_r ? 8'd0 : rdata;
        pend_err_nxt = oor_r;
      end
      if (cnt_r != 3'd0) begin
        addr_nxt = idx[ADDR_W-1:0];
        oor_nxt  = idx_oor;
        bits_nxt = {bits_r[6:0], 1'b0};
        cnt_nxt  = cnt_r - 3'd1;
      end
    end

    if (cmd.flush && pend_v_r) begin
      out_v_nxt  = 1'b1;
      out_nxt    = '{symbol: pend_sym_r, walk_error: pend_err_r, last: 1'b1};
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      walk_r    <= '0;
      cnt_r     <= 3'd0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      walk_r    <= walk_nxt;
      cnt_r     <= cnt_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    oor_r      <= oor_nxt;
    bits_r     <= bits_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_err_r <= pend_err_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    stat.clr_done = (clr_cnt_r == ADDR_W'(TREE_ENTRIES - 1));
    stat.last_bit = (cnt_r == 3'd0);
    stat.step_ok  = !(pend_v_r && !out_free);
    stat.flush_ok = !pend_v_r || out_free;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: rtl/huffman_heap_tree_decoder_top.sv
// Top level of the heap tree decoder: controller plus datapath.
// Depends on hhtd_pkg, hhtd_ctrl, hhtd_datapath and the assertion macro header.
//
// Channel   Direction  Handshake            Item
// in_       input      in_valid/in_stall    in_item_t (load entry or coded byte)
// out_      output     out_valid/out_stall  out_item_t (symbol, error, last)
//
// After reset the tree memory is cleared one entry a cycle, all 2048 entries,
// with in_stall high. A load item is written as it is accepted. A coded byte
// passes through acceptance, one tree memory read per bit (each read address
// comes from the previous read), and a flush that marks the last result. The
// walk holds while a result cannot move into a full, stalled output register.
`include "huffman_heap_tree_decoder_top_macros.svh"

module huffman_heap_tree_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hhtd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hhtd_pkg::out_item_t out_data
);
  import hhtd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hhtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hhtd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `HHTD_ASSERT_IMP(a_err_sym_zero, out_valid && out_data.walk_error, out_data.symbol == 8'd0, "error result carries a nonzero symbol")
  `HHTD_ASSERT_NXT(a_decode_busy, in_valid && !in_stall && in_data.func == FUNC_DECODE, in_stall, "decoder took a new item during a walk")
  `HHTD_ASSERT_NXT(a_load_ready, in_valid && !in_stall && in_data.func == FUNC_LOAD, !in_stall, "load item left the block busy")
  `HHTD_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({cmd.clr, cmd.load, cmd.start, cmd.step, cmd.flush}), "controller issued two commands at once")

endmodule
